[design/qyh_pkg.sv]
// Shared constants, types and the arctangent table for the quaternion yaw pipeline.
package qyh_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ZACC_FRAC       = 20;
    localparam int SCALE_SHIFT     = 8;

    localparam int FIELD_W = 16;
    localparam int PROD_W  = 2 * FIELD_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CW      = SUM_W + 1 + SCALE_SHIFT + 2;
    localparam int ZW      = ZACC_FRAC + 10;
    localparam int YW      = ANGLE_FRAC_BITS + 10;
    localparam int EW      = ((YW > FIELD_W) ? YW : FIELD_W) + 3;
    localparam int STAGE_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    localparam int FRONT_DEPTH = 3;
    localparam int BACK_DEPTH  = 2;
    localparam int PIPE_DEPTH  = FRONT_DEPTH + CORDIC_STAGES + BACK_DEPTH;

    localparam int DROP       = ZACC_FRAC - ANGLE_FRAC_BITS;
    localparam int HALF_TURN  = 180 * (1 << ANGLE_FRAC_BITS);
    localparam int FULL_TURN  = 2 * HALF_TURN;

    localparam logic signed [CW-1:0] ONE_Q        = CW'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam logic signed [ZW-1:0] QUARTER_Q20  = ZW'(90) <<< ZACC_FRAC;
    localparam logic signed [ZW-1:0] ROUND_BIAS   = ZW'(1) <<< (DROP - 1);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_q20(input logic [STAGE_W-1:0] idx);
        logic signed [ZW-1:0] r;
        case (int'(idx))
            0:       r = ZW'(47185920);
            1:       r = ZW'(27855475);
            2:       r = ZW'(14718068);
            3:       r = ZW'(7471121);
            4:       r = ZW'(3750058);
            5:       r = ZW'(1876857);
            6:       r = ZW'(938658);
            7:       r = ZW'(469357);
            8:       r = ZW'(234682);
            9:       r = ZW'(117342);
            10:      r = ZW'(58671);
            11:      r = ZW'(29335);
            12:      r = ZW'(14668);
            13:      r = ZW'(7334);
            14:      r = ZW'(3667);
            15:      r = ZW'(1833);
            16:      r = ZW'(917);
            17:      r = ZW'(458);
            18:      r = ZW'(229);
            19:      r = ZW'(115);
            20:      r = ZW'(57);
            21:      r = ZW'(29);
            22:      r = ZW'(14);
            23:      r = ZW'(7);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[design/quaternion_yaw_heading_error_top.sv]
// A request passes through the front end, CORDIC and back end register stages on its way to the result.
// Throughput: one request per cycle; each register stage advances whenever it or a
// later stage holds a bubble, so a waiting result blocks new requests only once all
// PIPE_DEPTH stages hold requests.
// Reset (rst_n low, asynchronous): all stage valid bits clear, target heading is 0.
// Top level: quaternion yaw and heading error pipeline with valid/stall handshakes.
module quaternion_yaw_heading_error_top
    import qyh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [FIELD_W-1:0]  quat_real,
    input  logic signed [FIELD_W-1:0]  quat_i,
    input  logic signed [FIELD_W-1:0]  quat_j,
    input  logic signed [FIELD_W-1:0]  quat_k,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [FIELD_W-1:0]  yaw_angle,
    output logic signed [FIELD_W-1:0]  reported_heading,
    output logic signed [FIELD_W-1:0]  heading_error,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic signed [FIELD_W-1:0]  cfg_data
);

    logic [PIPE_DEPTH-1:0]     valid_reg;
    logic [PIPE_DEPTH-1:0]     valid_next;
    logic [PIPE_DEPTH-1:0]     adv;
    logic signed [FIELD_W-1:0] target_reg;
    cordic_t                   stage_q [CORDIC_STAGES+1];

    always_comb
    begin
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            adv[k] = !out_stall ||
                     !(&(valid_reg | ((PIPE_DEPTH'(1) << k) - PIPE_DEPTH'(1))));
        end
    end

    always_comb
    begin
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            target_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign cfg_ready = 1'b1;

    qyh_front u_front (
        .clk       (clk),
        .en        (adv[FRONT_DEPTH-1:0]),
        .quat_real (quat_real),
        .quat_i    (quat_i),
        .quat_j    (quat_j),
        .quat_k    (quat_k),
        .q         (stage_q[0])
    );

    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_cordic
        qyh_cordic_stage u_stage (
            .clk   (clk),
            .en    (adv[FRONT_DEPTH+s]),
            .shift (STAGE_W'(s)),
            .d     (stage_q[s]),
            .q     (stage_q[s+1])
        );
    end

    qyh_back u_back (
        .clk              (clk),
        .en               (adv[PIPE_DEPTH-1:PIPE_DEPTH-BACK_DEPTH]),
        .d                (stage_q[CORDIC_STAGES]),
        .target           (target_reg),
        .yaw_angle        (yaw_angle),
        .reported_heading (reported_heading),
        .heading_error    (heading_error)
    );

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted request did not enter the first stage");

    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> !in_stall)
        else $error("input stalled with an empty first stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(heading_error))
        else $error("stalled result was lost or changed");

    a_heading_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reported_heading == FIELD_W'(-yaw_angle))
        else $error("reported heading is not the negated yaw");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_error >= -FIELD_W'(HALF_TURN)) &&
                      (heading_error < FIELD_W'(HALF_TURN)))
        else $error("heading error outside the half-open turn");

endmodule

[design/qyh_front.sv]
// Front end: component products, x and y forming, and quarter-turn pre-rotation.
module qyh_front
    import qyh_pkg::*;
(
    input  logic                       clk,
    input  logic [FRONT_DEPTH-1:0]     en,
    input  logic signed [FIELD_W-1:0]  quat_real,
    input  logic signed [FIELD_W-1:0]  quat_i,
    input  logic signed [FIELD_W-1:0]  quat_j,
    input  logic signed [FIELD_W-1:0]  quat_k,
    output cordic_t                    q
);

    logic signed [PROD_W-1:0] p_rk_reg;
    logic signed [PROD_W-1:0] p_ij_reg;
    logic signed [PROD_W-1:0] p_jj_reg;
    logic signed [PROD_W-1:0] p_kk_reg;

    logic signed [SUM_W-1:0]  sum_y;
    logic signed [SUM_W-1:0]  sum_sq;
    logic signed [CW-1:0]     x_next;
    logic signed [CW-1:0]     y_next;
    logic signed [CW-1:0]     x_reg;
    logic signed [CW-1:0]     y_reg;
    logic                     zero_reg;
    cordic_t                  rot_next;
    cordic_t                  rot_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_rk_reg <= quat_real * quat_k;
            p_ij_reg <= quat_i * quat_j;
            p_jj_reg <= quat_j * quat_j;
            p_kk_reg <= quat_k * quat_k;
        end
    end

    always_comb
    begin
        sum_y  = SUM_W'(p_rk_reg) + SUM_W'(p_ij_reg);
        sum_sq = SUM_W'(p_jj_reg) + SUM_W'(p_kk_reg);
        y_next = CW'(sum_y) <<< (SCALE_SHIFT + 1);
        x_next = (ONE_Q - (CW'(sum_sq) <<< 1)) <<< SCALE_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            zero_reg <= (x_next == '0) && (y_next == '0);
        end
    end

    always_comb
    begin
        rot_next.zero = zero_reg;
        rot_next.x    = x_reg;
        rot_next.y    = y_reg;
        rot_next.z    = '0;
        if (x_reg < 0)
        begin
            if (y_reg >= 0)
            begin
                rot_next.x = y_reg;
                rot_next.y = -x_reg;
                rot_next.z = QUARTER_Q20;
            end
            else
            begin
                rot_next.x = -y_reg;
                rot_next.y = x_reg;
                rot_next.z = -QUARTER_Q20;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rot_reg <= rot_next;
        end
    end

    assign q = rot_reg;

endmodule

[design/qyh_cordic_stage.sv]
// One vectoring-mode CORDIC micro-rotation with its pipeline register.
module qyh_cordic_stage
    import qyh_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [STAGE_W-1:0] shift,
    input  cordic_t            d,
    output cordic_t            q
);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] step;
    cordic_t              q_next;
    cordic_t              q_reg;

    always_comb
    begin
        xs          = d.x >>> shift;
        ys          = d.y >>> shift;
        step        = atan_q20(shift);
        q_next.zero = d.zero;
        if (d.y >= 0)
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + step;
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[design/qyh_back.sv]
// Back end: yaw rounding and half-turn fold, heading error wrap, output registers.
module qyh_back
    import qyh_pkg::*;
(
    input  logic                       clk,
    input  logic [BACK_DEPTH-1:0]      en,
    input  cordic_t                    d,
    input  logic signed [FIELD_W-1:0]  target,
    output logic signed [FIELD_W-1:0]  yaw_angle,
    output logic signed [FIELD_W-1:0]  reported_heading,
    output logic signed [FIELD_W-1:0]  heading_error
);

    logic signed [ZW-1:0]      rnd;
    logic signed [YW-1:0]      yaw_next;
    logic signed [YW-1:0]      yaw_reg;
    logic signed [YW-1:0]      neg_yaw;
    logic signed [EW-1:0]      err_raw;
    logic signed [EW-1:0]      err_next;
    logic signed [FIELD_W-1:0] yaw_out_reg;
    logic signed [FIELD_W-1:0] head_out_reg;
    logic signed [FIELD_W-1:0] err_out_reg;

    always_comb
    begin
        rnd      = (d.z + ROUND_BIAS) >>> DROP;
        yaw_next = d.zero ? '0 : YW'(rnd);
        if (yaw_next > YW'(HALF_TURN))
        begin
            yaw_next = yaw_next - YW'(FULL_TURN);
        end
        else if (yaw_next < -YW'(HALF_TURN))
        begin
            yaw_next = yaw_next + YW'(FULL_TURN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            yaw_reg <= yaw_next;
        end
    end

    always_comb
    begin
        neg_yaw  = -yaw_reg;
        err_raw  = EW'(target) - EW'(yaw_reg) + EW'(HALF_TURN);
        err_next = err_raw;
        if (err_raw < 0)
        begin
            err_next = err_raw + EW'(FULL_TURN);
        end
        else if (err_raw >= EW'(FULL_TURN))
        begin
            err_next = err_raw - EW'(FULL_TURN);
        end
        err_next = err_next - EW'(HALF_TURN);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            yaw_out_reg  <= yaw_reg[FIELD_W-1:0];
            head_out_reg <= neg_yaw[FIELD_W-1:0];
            err_out_reg  <= err_next[FIELD_W-1:0];
        end
    end

    assign yaw_angle        = yaw_out_reg;
    assign reported_heading = head_out_reg;
    assign heading_error    = err_out_reg;

endmodule

[tb/sv/tb_quaternion_yaw_heading_error_top.sv]
// Self-checking testbench for the quaternion yaw and heading error pipeline.
`timescale 1ns / 100ps

module tb_quaternion_yaw_heading_error_top;
    import qyh_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 193;
    localparam int TAIL_ITEMS  = 120;

    localparam longint ATAN_DEG_Q20 [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct {
        bit                        is_cfg;
        logic signed [FIELD_W-1:0] tgt;
        logic signed [FIELD_W-1:0] qr;
        logic signed [FIELD_W-1:0] qi;
        logic signed [FIELD_W-1:0] qj;
        logic signed [FIELD_W-1:0] qk;
    } quat_req_t;

    typedef struct {
        logic signed [FIELD_W-1:0] yaw;
        logic signed [FIELD_W-1:0] heading;
        logic signed [FIELD_W-1:0] err;
    } heading_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [FIELD_W-1:0] quat_real = '0;
    logic signed [FIELD_W-1:0] quat_i = '0;
    logic signed [FIELD_W-1:0] quat_j = '0;
    logic signed [FIELD_W-1:0] quat_k = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [FIELD_W-1:0] yaw_angle;
    logic signed [FIELD_W-1:0] reported_heading;
    logic signed [FIELD_W-1:0] heading_error;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic signed [FIELD_W-1:0] cfg_data = '0;

    quat_req_t                 pending_q[$];
    heading_t                  heading_q[$];
    logic signed [FIELD_W-1:0] target_model = '0;
    int                        n_sent = 0;
    int                        n_got = 0;
    int                        errors = 0;
    int                        cycles = 0;
    logic                      calm_tail = 1'b0;
    int                        gap_left = 0;
    int                        in_calm = 0;
    int                        stall_left = 0;
    int                        out_calm = 0;

    quaternion_yaw_heading_error_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .quat_real        (quat_real),
        .quat_i           (quat_i),
        .quat_j           (quat_j),
        .quat_k           (quat_k),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .yaw_angle        (yaw_angle),
        .reported_heading (reported_heading),
        .heading_error    (heading_error),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    function automatic heading_t predict_heading(
        input logic signed [FIELD_W-1:0] qr,
        input logic signed [FIELD_W-1:0] qi,
        input logic signed [FIELD_W-1:0] qj,
        input logic signed [FIELD_W-1:0] qk,
        input logic signed [FIELD_W-1:0] tgt
    );
        longint   a, b, c, d, x, y, z, t, xs, ys, yaw, err, half, full, tg;
        int       drop;
        heading_t r;
        a    = qr;
        b    = qi;
        c    = qj;
        d    = qk;
        tg   = tgt;
        half = 180 * (longint'(1) << ANGLE_FRAC_BITS);
        full = 2 * half;
        drop = ZACC_FRAC - ANGLE_FRAC_BITS;
        y    = 2 * (a * d + b * c) * 256;
        x    = ((longint'(1) << (2 * QUAT_FRAC_BITS)) - 2 * (c * c + d * d)) * 256;
        z    = 0;
        if (x != 0 || y != 0)
        begin
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x;
                    x = y;
                    y = -t;
                    z = 90 * (longint'(1) << ZACC_FRAC);
                end
                else
                begin
                    t = x;
                    x = -y;
                    y = t;
                    z = -90 * (longint'(1) << ZACC_FRAC);
                end
            end
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG_Q20[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG_Q20[i];
                end
            end
        end
        yaw = (z + (longint'(1) << (drop - 1))) >>> drop;
        if (yaw > half)
            yaw = yaw - full;
        else if (yaw < -half)
            yaw = yaw + full;
        err = (tg - yaw + half) % full;
        if (err < 0)
            err = err + full;
        err = err - half;
        r.yaw     = yaw[FIELD_W-1:0];
        r.heading = FIELD_W'(-yaw);
        r.err     = err[FIELD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] corner_value();
        logic signed [FIELD_W-1:0] picks [8];
        picks = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767,
                  16'sd16384, -16'sd16384, 16'sd8192};
        return picks[$urandom_range(0, 7)];
    endfunction

    function automatic quat_req_t random_quat();
        quat_req_t q;
        int        sj, sk, m;
        q.is_cfg = 1'b0;
        q.tgt    = '0;
        q.qr     = FIELD_W'($urandom);
        q.qi     = FIELD_W'($urandom);
        q.qj     = FIELD_W'($urandom);
        q.qk     = FIELD_W'($urandom);
        case ($urandom_range(0, 9))
            4, 5:
            begin
                q.qr = FIELD_W'($urandom_range(0, 32768) - 16384);
                q.qk = FIELD_W'($urandom_range(0, 32768) - 16384);
                q.qi = FIELD_W'($urandom_range(0, 4096) - 2048);
                q.qj = FIELD_W'($urandom_range(0, 4096) - 2048);
            end
            6:
            begin
                q.qr = corner_value();
                q.qi = corner_value();
                q.qj = corner_value();
                q.qk = corner_value();
            end
            7:
            begin
                q.qr = '0;
                q.qi = '0;
            end
            8:
            begin
                sj   = $urandom_range(0, 1) ? 1 : -1;
                sk   = $urandom_range(0, 1) ? 1 : -1;
                m    = $urandom_range(0, 65534) - 32767;
                q.qr = FIELD_W'(m);
                q.qi = FIELD_W'(-m * sj * sk);
                q.qj = FIELD_W'(sj * 8192);
                q.qk = FIELD_W'(sk * 8192);
            end
            9:
            begin
                m    = $urandom_range(12000, 32767);
                q.qr = FIELD_W'($urandom_range(0, 6) - 3);
                q.qi = '0;
                q.qj = '0;
                q.qk = $urandom_range(0, 1) ? FIELD_W'(m) : FIELD_W'(-m);
            end
            default:
            begin
            end
        endcase
        return q;
    endfunction

    task automatic queue_quat(input int qr, input int qi, input int qj, input int qk);
        quat_req_t q;
        q.is_cfg = 1'b0;
        q.tgt    = '0;
        q.qr     = FIELD_W'(qr);
        q.qi     = FIELD_W'(qi);
        q.qj     = FIELD_W'(qj);
        q.qk     = FIELD_W'(qk);
        pending_q.push_back(q);
    endtask

    task automatic queue_target(input int value);
        quat_req_t q;
        q.is_cfg = 1'b1;
        q.tgt    = FIELD_W'(value);
        q.qr     = '0;
        q.qi     = '0;
        q.qj     = '0;
        q.qk     = '0;
        pending_q.push_back(q);
    endtask

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_quaternion_yaw_heading_error_top: done, errors");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : driver
        quat_req_t head;
        logic      nv;
        logic      ncv;
        int        sent;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            calm_tail <= 1'b0;
        end
        else
        begin
            nv   = in_valid;
            ncv  = cfg_valid;
            sent = n_sent;
            if (cfg_valid && cfg_ready)
            begin
                target_model = cfg_data;
                ncv          = 1'b0;
            end
            if (in_valid && !in_stall)
            begin
                heading_q.push_back(predict_heading(quat_real, quat_i, quat_j, quat_k,
                                                    target_model));
                sent = sent + 1;
                nv   = 1'b0;
            end
            if (in_calm > 0)
                in_calm--;
            else if ($urandom_range(0, 39) == 0)
                in_calm = $urandom_range(30, 80);
            if (!nv && !ncv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    head = pending_q[0];
                    if (head.is_cfg)
                    begin
                        // hold the write until every request has come back
                        if (sent == n_got)
                        begin
                            ncv = 1'b1;
                            cfg_data <= head.tgt;
                            void'(pending_q.pop_front());
                        end
                    end
                    else
                    begin
                        nv = 1'b1;
                        quat_real <= head.qr;
                        quat_i    <= head.qi;
                        quat_j    <= head.qj;
                        quat_k    <= head.qk;
                        void'(pending_q.pop_front());
                        if (!calm_tail && in_calm == 0 && $urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(1, 10);
                    end
                end
            end
            in_valid  <= nv;
            cfg_valid <= ncv;
            n_sent    <= sent;
            calm_tail <= (pending_q.size() < TAIL_ITEMS);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        heading_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (heading_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = heading_q.pop_front();
                    if (yaw_angle !== want.yaw)
                    begin
                        $error("yaw_angle: expected %0d, got %0d", want.yaw, yaw_angle);
                        errors++;
                    end
                    if (reported_heading !== want.heading)
                    begin
                        $error("reported_heading: expected %0d, got %0d",
                               want.heading, reported_heading);
                        errors++;
                    end
                    if (heading_error !== want.err)
                    begin
                        $error("heading_error: expected %0d, got %0d",
                               want.err, heading_error);
                        errors++;
                    end
                end
                n_got <= n_got + 1;
            end
            if (out_calm > 0)
                out_calm--;
            else if ($urandom_range(0, 39) == 0)
                out_calm = $urandom_range(30, 80);
            if (stall_left == 0 && !calm_tail && out_calm == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        queue_quat(16384, 0, 0, 0);
        queue_quat(0, 0, 0, 0);
        queue_quat(0, 0, 8192, 8192);
        queue_quat(5000, -5000, -8192, -8192);
        queue_quat(0, 0, 0, 16384);
        queue_quat(0, 0, 16384, 0);
        queue_quat(0, 16384, 0, 0);
        queue_quat(11585, 0, 0, 11585);
        queue_quat(11585, 0, 0, -11585);
        queue_quat(1, 0, 0, 16384);
        queue_quat(-1, 0, 0, 16384);
        queue_quat(1, 0, 0, -16384);
        queue_quat(-32768, -32768, -32768, -32768);
        queue_quat(32767, 32767, 32767, 32767);
        queue_quat(32767, -32768, 32767, -32768);
        queue_quat(-32768, 32767, -32768, 32767);
        queue_quat(-32768, 0, 0, 0);
        queue_quat(0, -32768, 0, 32767);
        queue_quat(32767, 0, 0, -32768);
        queue_quat(14189, 0, 0, 8192);
        queue_quat(-14189, 0, 0, 8192);
        queue_quat(-1, -1, -1, -1);

        queue_target(23039);
        repeat (PHASE_ITEMS) pending_q.push_back(random_quat());
        queue_target(-23040);
        repeat (PHASE_ITEMS) pending_q.push_back(random_quat());
        queue_target(32767);
        repeat (PHASE_ITEMS) pending_q.push_back(random_quat());
        queue_target(-32768);
        repeat (PHASE_ITEMS) pending_q.push_back(random_quat());
        queue_target($urandom_range(0, 46079) - 23040);
        repeat (PHASE_ITEMS) pending_q.push_back(random_quat());
        queue_target(int'($urandom_range(0, 65535)) - 32768);
        repeat (PHASE_ITEMS) pending_q.push_back(random_quat());
        queue_target(0);
        repeat (PHASE_ITEMS) pending_q.push_back(random_quat());

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || in_valid || cfg_valid || n_got != n_sent)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (heading_q.size() != 0)
        begin
            $error("%0d results never arrived", heading_q.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_quaternion_yaw_heading_error_top: done, clean");
        else
            $display("tb_quaternion_yaw_heading_error_top: done, errors");
        $finish;
    end

endmodule
